>>> hdl/sm4_pkg.sv
// ============================================================================
// sm4_pkg - SM4 cipher shared types and constants
// S-box, system parameter FK, CK words, sequencer states and helpers.
// ============================================================================
package sm4_pkg;

    localparam int WORD_W  = 32;
    localparam int HALF_W  = 64;
    localparam int BLOCK_W = 128;
    localparam int ROUNDS  = 32;
    localparam int RND_W   = $clog2(ROUNDS);

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [HALF_W-1:0]  half_t;
    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [RND_W-1:0]   rnd_t;
    typedef logic [0:0]         cfg_index_t;

    // register indexes
    localparam cfg_index_t REG_KEY_UPPER = 1'b0;
    localparam cfg_index_t REG_KEY_LOWER = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEXP,
        ST_LOAD,
        ST_ROUND,
        ST_DRAIN
    } state_t;

    localparam block_t FK = 128'hA3B1BAC6_56AA3350_677D9197_B27022DC;

    localparam word_t CK_TAB [ROUNDS] = '{
        32'h00070E15, 32'h1C232A31, 32'h383F464D, 32'h545B6269,
        32'h70777E85, 32'h8C939AA1, 32'hA8AFB6BD, 32'hC4CBD2D9,
        32'hE0E7EEF5, 32'hFC030A11, 32'h181F262D, 32'h343B4249,
        32'h50575E65, 32'h6C737A81, 32'h888F969D, 32'hA4ABB2B9,
        32'hC0C7CED5, 32'hDCE3EAF1, 32'hF8FF060D, 32'h141B2229,
        32'h30373E45, 32'h4C535A61, 32'h686F767D, 32'h848B9299,
        32'hA0A7AEB5, 32'hBCC3CAD1, 32'hD8DFE6ED, 32'hF4FB0209,
        32'h10171E25, 32'h2C333A41, 32'h484F565D, 32'h646B7279
    };

    localparam logic [7:0] SBOX_TAB [256] = '{
        8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,
        8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
        8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,
        8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,
        8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
        8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,
        8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
        8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,
        8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
        8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,
        8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
        8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,
        8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
        8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,
        8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
        8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,
        8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
        8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,
        8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
        8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,
        8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
        8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,
        8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
        8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,
        8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
        8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,
        8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
        8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,
        8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
        8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,
        8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
    };

    function automatic word_t sub_word(input word_t v);
        return {SBOX_TAB[v[31:24]], SBOX_TAB[v[23:16]],
                SBOX_TAB[v[15:8]],  SBOX_TAB[v[7:0]]};
    endfunction

    function automatic word_t rotl(input word_t v, input int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    // L transform of the data path
    function automatic word_t lin_data(input word_t b);
        return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    // L' transform of the key schedule
    function automatic word_t lin_key(input word_t b);
        return b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

endpackage

>>> hdl/sm4_in_if.sv
// ============================================================================
// sm4_in_if - SM4 input block channel
// Valid/ready channel carrying one block and the direction bit per beat.
// ============================================================================
interface sm4_in_if;
    logic                 valid;
    logic                 ready;
    logic [63:0]          block_upper;
    logic [63:0]          block_lower;
    logic                 direction;

    modport source (output valid, output block_upper, output block_lower,
                    output direction, input ready);
    modport sink   (input valid, input block_upper, input block_lower,
                    input direction, output ready);
endinterface

>>> hdl/sm4_out_if.sv
// ============================================================================
// sm4_out_if - SM4 result block channel
// Valid/ready channel carrying one result block per beat.
// ============================================================================
interface sm4_out_if;
    logic                 valid;
    logic                 ready;
    logic [63:0]          out_upper;
    logic [63:0]          out_lower;

    modport source (output valid, output out_upper, output out_lower, input ready);
    modport sink   (input valid, input out_upper, input out_lower, output ready);
endinterface

>>> hdl/sm4_block_cipher.sv
// ============================================================================
// sm4_block_cipher - round-iterative SM4 encrypt/decrypt core
// One shared S-box/L unit runs the key schedule and the 32 cipher rounds.
// ============================================================================
// Usage:
//   in_ch  : one beat = 128-bit block (block_upper = words 0,1; block_lower =
//            words 2,3) plus direction (0 encrypt, 1 decrypt).
//   out_ch : one beat per input beat, same word layout.
//   cfg    : cfg_we/cfg_index/cfg_data write key_upper (0) or key_lower (1).
//            Write only while the core is idle.
// Sequence: an accepted beat passes LOAD, the cipher rounds in ROUND and DRAIN,
//   where the result is registered. After a key write the first block also
//   runs the key schedule in KEXP first; later blocks reuse the stored keys.
// Blocks run one at a time, limited by the single T-transform unit doing
//   one round per cycle; in_ch.ready is high only while the sequencer is
//   idle, so no new block is taken before the last one is through DRAIN.
// Reset: key cleared to zero, round-key store marked stale, no result held.
// Stall: the result sits in the output register; the core still accepts the
//   next block and runs it, then waits in DRAIN until the register frees.
// ============================================================================
module sm4_block_cipher (
    input  logic                  clk,
    input  logic                  rst_n,
    sm4_in_if.sink                in_ch,
    sm4_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  sm4_pkg::cfg_index_t   cfg_index,
    input  sm4_pkg::half_t        cfg_data
);
    import sm4_pkg::*;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t  state_reg, state_next;
    rnd_t    cnt_reg, cnt_next;
    logic    stale_reg, stale_next;
    logic    dir_reg;
    half_t   key_upper_reg, key_lower_reg;
    block_t  kwin_reg;        // key schedule window k[i..i+3]
    block_t  xwin_reg;        // data window x[i..i+3]
    word_t   rk_reg;          // registered round-key read
    logic    out_valid_reg;
    half_t   out_upper_reg, out_lower_reg;

    // round-key store, written by the key schedule, read ahead of each round into rk_reg
    word_t   rk_mem [ROUNDS];

    // ------------------------------------------------------------------
    // Sequencer controls
    // ------------------------------------------------------------------
    logic    in_take;
    logic    kexp_init;
    logic    kexp_step;
    logic    round_step;
    logic    out_free;
    logic    out_load;
    rnd_t    rd_round;
    rnd_t    rd_addr;

    // ------------------------------------------------------------------
    // Shared T / T' unit
    // ------------------------------------------------------------------
    word_t   t_in;
    word_t   t_sb;
    word_t   t_out;
    word_t   key_new;
    word_t   data_new;

    always_comb
    begin
        if (state_reg == ST_KEXP)
        begin
            t_in = kwin_reg[95:64] ^ kwin_reg[63:32] ^ kwin_reg[31:0] ^ CK_TAB[cnt_reg];
        end
        else
        begin
            t_in = xwin_reg[95:64] ^ xwin_reg[63:32] ^ xwin_reg[31:0] ^ rk_reg;
        end
        t_sb     = sub_word(t_in);
        t_out    = (state_reg == ST_KEXP) ? lin_key(t_sb) : lin_data(t_sb);
        key_new  = kwin_reg[127:96] ^ t_out;
        data_new = xwin_reg[127:96] ^ t_out;
    end

    assign out_free = !out_valid_reg || out_ch.ready;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = stale_reg ? ST_KEXP : ST_LOAD;
                end
            end
            ST_KEXP:
            begin
                if (cnt_reg == rnd_t'(ROUNDS - 1))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (cnt_reg == rnd_t'(ROUNDS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ch.ready = 1'b0;
        in_take     = 1'b0;
        kexp_init   = 1'b0;
        kexp_step   = 1'b0;
        round_step  = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                in_take     = in_ch.valid;
                kexp_init   = in_ch.valid && stale_reg;
            end
            ST_KEXP:
            begin
                kexp_step = 1'b1;
            end
            ST_LOAD:
            begin
            end
            ST_ROUND:
            begin
                round_step = 1'b1;
            end
            ST_DRAIN:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // round index whose key is fetched this cycle; decrypt walks backwards
    assign rd_round = (state_reg == ST_LOAD) ? '0 : rnd_t'(cnt_reg + 1'b1);
    assign rd_addr  = dir_reg ? ~rd_round : rd_round;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (kexp_step || round_step)
        begin
            cnt_next = rnd_t'(cnt_reg + 1'b1);
        end
        else if (state_reg == ST_IDLE)
        begin
            cnt_next = '0;
        end
    end

    always_comb
    begin
        stale_next = stale_reg;
        if (kexp_step && (cnt_reg == rnd_t'(ROUNDS - 1)))
        begin
            stale_next = 1'b0;
        end
        if (cfg_we)
        begin
            stale_next = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            stale_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            key_upper_reg <= '0;
            key_lower_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            stale_reg <= stale_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_KEY_UPPER: key_upper_reg <= cfg_data;
                    REG_KEY_LOWER: key_lower_reg <= cfg_data;
                    default:       key_upper_reg <= key_upper_reg;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            dir_reg  <= in_ch.direction;
            xwin_reg <= {in_ch.block_upper, in_ch.block_lower};
        end
        else if (round_step)
        begin
            xwin_reg <= {xwin_reg[95:0], data_new};
        end

        if (kexp_init)
        begin
            kwin_reg <= {key_upper_reg, key_lower_reg} ^ FK;
        end
        else if (kexp_step)
        begin
            kwin_reg <= {kwin_reg[95:0], key_new};
        end

        if (out_load)
        begin
            // final output is the last four words in reverse order
            out_upper_reg <= {xwin_reg[31:0], xwin_reg[63:32]};
            out_lower_reg <= {xwin_reg[95:64], xwin_reg[127:96]};
        end
    end

    // round-key store
    always_ff @(posedge clk)
    begin
        if (kexp_step)
        begin
            rk_mem[cnt_reg] <= key_new;
        end
        rk_reg <= rk_mem[rd_addr];
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_upper = out_upper_reg;
    assign out_ch.out_lower = out_lower_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DRAIN))
        else $error("result register loaded outside DRAIN");

    a_kexp_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KEXP && cnt_reg == rnd_t'(ROUNDS - 1))
        |=> (state_reg == ST_LOAD))
        else $error("key schedule did not hand over to LOAD");

    a_round_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && cnt_reg == rnd_t'(ROUNDS - 1))
        |=> (state_reg == ST_DRAIN && cnt_reg == '0))
        else $error("round count did not end in DRAIN");

    a_load_needs_keys: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> ($past(state_reg) == ST_KEXP || !$past(stale_reg)))
        else $error("rounds started on a stale round-key store");

endmodule

>>> tb/sm4_block_cipher_tb.sv
// ============================================================================
// sm4_block_cipher_tb - self-checking bench for the SM4 encrypt/decrypt core
// Drives blocks through the input channel under a series of keys, predicts
// every result with an independent SM4 model, and compares each output beat
// in order. Both channels idle at random in two of three mixes to stress the handshakes.
// ============================================================================
module sm4_block_cipher_tb;
    import sm4_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int CHUNK_ITEMS   = 135;
    localparam int SETTLE_CYCLES = 70;    // key schedule + one block + slack
    localparam int QUIET_LIMIT   = 3000;  // cycles without any beat or write
    localparam int SHOW_LIMIT    = 10;

    // Own S-box copy, standard table
    localparam logic [7:0] SBOX_LUT [256] = '{
        8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
        8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
        8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
        8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
        8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
        8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
        8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
        8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
        8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
        8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
        8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
        8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
        8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
        8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
        8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
    };

    // Key schedule system parameter, own copy
    localparam word_t FK_0 = 32'hA3B1BAC6;
    localparam word_t FK_1 = 32'h56AA3350;
    localparam word_t FK_2 = 32'h677D9197;
    localparam word_t FK_3 = 32'hB27022DC;

    typedef struct packed {
        block_t data;
        logic   decrypt;
    } block_item_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    cfg_index_t  cfg_index;
    half_t       cfg_data;

    sm4_in_if    in_ch ();
    sm4_out_if   out_ch ();

    sm4_block_cipher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Bench copy of the key and the round keys derived from it
    half_t       key_upper;
    half_t       key_lower;
    word_t       round_keys [ROUNDS];

    block_item_t pending_blocks [$];
    block_t      expected_results [$];
    block_item_t next_block;

    int          send_idle_pct;
    int          recv_idle_pct;
    int          blocks_queued;
    int          blocks_accepted;
    int          decrypts_accepted;
    int          results_checked;
    int          key_settings;
    int          mismatches;
    int          quiet_cycles;

    // ------------------------------------------------------------------------
    // SM4 predictor
    // ------------------------------------------------------------------------
    function automatic word_t sbox_word(word_t w);
        word_t s;
        for (int j = 0; j < 4; j++)
            s[8*j +: 8] = SBOX_LUT[w[8*j +: 8]];
        return s;
    endfunction

    // data round: S-box then linear mix with rotations 2, 10, 18, 24
    function automatic word_t round_fn(word_t w);
        word_t b;
        b = sbox_word(w);
        return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                 ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    endfunction

    // key schedule: S-box then linear mix with rotations 13, 23
    function automatic word_t sched_fn(word_t w);
        word_t b;
        b = sbox_word(w);
        return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
    endfunction

    function automatic void expand_key();
        word_t k [ROUNDS+4];
        word_t ck;
        k[0] = key_upper[63:32] ^ FK_0;
        k[1] = key_upper[31:0]  ^ FK_1;
        k[2] = key_lower[63:32] ^ FK_2;
        k[3] = key_lower[31:0]  ^ FK_3;
        for (int i = 0; i < ROUNDS; i++)
        begin
            // CK byte j of word i is (4i+j)*7 mod 256
            for (int j = 0; j < 4; j++)
                ck[31-8*j -: 8] = 8'((4*i + j) * 7);
            k[i+4] = k[i] ^ sched_fn(k[i+1] ^ k[i+2] ^ k[i+3] ^ ck);
            round_keys[i] = k[i+4];
        end
    endfunction

    function automatic block_t sm4_crypt(block_t blk, logic decrypt);
        word_t x [ROUNDS+4];
        word_t rk;
        x[0] = blk[127:96];
        x[1] = blk[95:64];
        x[2] = blk[63:32];
        x[3] = blk[31:0];
        for (int i = 0; i < ROUNDS; i++)
        begin
            rk     = decrypt ? round_keys[ROUNDS-1-i] : round_keys[i];
            x[i+4] = x[i] ^ round_fn(x[i+1] ^ x[i+2] ^ x[i+3] ^ rk);
        end
        // output is the last four words, reversed
        return {x[35], x[34], x[33], x[32]};
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Driver: presents queued blocks, holds a beat until accepted, and
    // predicts the result from what was actually accepted.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.block_upper <= '0;
            in_ch.block_lower <= '0;
            in_ch.direction   <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_results.push_back(
                    sm4_crypt({in_ch.block_upper, in_ch.block_lower}, in_ch.direction));
                blocks_accepted++;
                if (in_ch.direction)
                    decrypts_accepted++;
            end
            // a held beat stays untouched; otherwise pick the next one or idle
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_blocks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_block        = pending_blocks.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.block_upper <= next_block.data[127:64];
                    in_ch.block_lower <= next_block.data[63:0];
                    in_ch.direction   <= next_block.decrypt;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random back-pressure, in-order compare of each result beat
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string field, half_t want, half_t got);
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
            $display("mismatch on %s at result %0d: expected %h, got %h",
                     field, results_checked, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display("result beat with nothing expected: %h %h",
                                 out_ch.out_upper, out_ch.out_lower);
                end
                else
                begin
                    if (expected_results[0][127:64] !== out_ch.out_upper)
                        report_mismatch("out_upper", expected_results[0][127:64],
                                        out_ch.out_upper);
                    if (expected_results[0][63:0] !== out_ch.out_lower)
                        report_mismatch("out_lower", expected_results[0][63:0],
                                        out_ch.out_lower);
                    void'(expected_results.pop_front());
                end
                results_checked++;
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any beat or register write counts as progress
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
        $display("sm4_block_cipher_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_block(block_t data, logic decrypt);
        block_item_t b;
        b.data    = data;
        b.decrypt = decrypt;
        pending_blocks.push_back(b);
        blocks_queued++;
    endtask

    // every queued block accepted and every result beat seen
    task automatic wait_drained();
        while (blocks_accepted != blocks_queued || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // one register write; the bench key copy follows it
    task automatic write_key_reg(cfg_index_t idx, half_t value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_KEY_UPPER)
            key_upper = value;
        else
            key_lower = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        expand_key();
    endtask

    function automatic block_t rand_block();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic half_t rand_half();
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        block_t blk;
        logic   dir;
        int     made;
        int     pick;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_KEY_UPPER;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.block_upper = '0;
        in_ch.block_lower = '0;
        in_ch.direction   = 1'b0;
        out_ch.ready      = 1'b0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        blocks_queued     = 0;
        blocks_accepted   = 0;
        decrypts_accepted = 0;
        results_checked   = 0;
        key_settings      = 1;
        mismatches        = 0;
        quiet_cycles      = 0;
        key_upper         = '0;
        key_lower         = '0;
        expand_key();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed: key never written, so the all-zero key applies
        queue_block('0, 1'b0);
        queue_block('0, 1'b1);
        queue_block('1, 1'b0);
        queue_block('1, 1'b1);
        wait_drained();

        // --- directed: standard test key, plaintext equal to key, round trip
        write_key_reg(REG_KEY_UPPER, 64'h01234567_89ABCDEF);
        write_key_reg(REG_KEY_LOWER, 64'hFEDCBA98_76543210);
        key_settings++;
        queue_block(128'h01234567_89ABCDEF_FEDCBA98_76543210, 1'b0);
        queue_block(128'h681EDF34_D206965E_86B3E94F_536E4246, 1'b1);
        queue_block({64{2'b01}}, 1'b0);
        queue_block({64{2'b10}}, 1'b1);
        queue_block({64'h0, {64{1'b1}}}, 1'b0);
        queue_block({{64{1'b1}}, 64'h0}, 1'b1);
        wait_drained();

        // --- directed: all-ones key, single-bit blocks at both ends
        write_key_reg(REG_KEY_UPPER, '1);
        write_key_reg(REG_KEY_LOWER, '1);
        key_settings++;
        queue_block('0, 1'b0);
        queue_block('1, 1'b1);
        queue_block(128'h01234567_89ABCDEF_FEDCBA98_76543210, 1'b0);
        queue_block(128'h1, 1'b0);
        queue_block({1'b1, 127'h0}, 1'b1);
        wait_drained();

        // --- directed: rewrite only the lower half, upper keeps all ones
        write_key_reg(REG_KEY_LOWER, '0);
        key_settings++;
        queue_block('0, 1'b0);
        queue_block('0, 1'b1);
        queue_block('1, 1'b0);
        wait_drained();

        // --- random: three idle mixes, four key settings each
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0: begin send_idle_pct = 38; recv_idle_pct = 69; end
                1: begin send_idle_pct = 69; recv_idle_pct = 38; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase

            for (int chunk = 0; chunk < 4; chunk++)
            begin
                // key changes only with the core idle
                wait_drained();
                case (chunk)
                    0:
                    begin
                        write_key_reg(REG_KEY_UPPER, rand_half());
                        write_key_reg(REG_KEY_LOWER, rand_half());
                    end
                    1:
                    begin
                        // extremes: ones/zeros, zeros/ones, ones/ones
                        write_key_reg(REG_KEY_UPPER, (mode == 1) ? '0 : '1);
                        write_key_reg(REG_KEY_LOWER, (mode == 0) ? '0 : '1);
                    end
                    2: write_key_reg(REG_KEY_UPPER, rand_half());
                    default: write_key_reg(REG_KEY_LOWER, rand_half());
                endcase
                key_settings++;

                made = 0;
                while (made < CHUNK_ITEMS)
                begin
                    // sender holds off at most once per mix until the core is empty
                    if (chunk == 2 && made == CHUNK_ITEMS / 2)
                        wait_drained();
                    pick = $urandom_range(0, 9);
                    dir  = 1'($urandom_range(0, 1));
                    if (pick == 0)
                    begin
                        // sparse block: one bit set or one bit clear
                        blk = 128'h1 << $urandom_range(0, 127);
                        if ($urandom_range(0, 1))
                            blk = ~blk;
                        queue_block(blk, dir);
                        made++;
                    end
                    else if (pick <= 2)
                    begin
                        // round trip: the second beat must give back the first block
                        blk = rand_block();
                        queue_block(blk, dir);
                        queue_block(sm4_crypt(blk, dir), ~dir);
                        made += 2;
                    end
                    else
                    begin
                        queue_block(rand_block(), dir);
                        made++;
                    end
                end
            end
        end

        // let the last beats through, then give any stray result time to show
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d blocks sent (%0d decrypt), %0d results checked, %0d keys used",
                 blocks_accepted, decrypts_accepted, results_checked, key_settings);
        $display("idle mixes: sender-heavy, receiver-heavy and none; %0d mismatches",
                 mismatches);
        mismatches += expected_results.size();
        if (mismatches == 0)
            $display("sm4_block_cipher_tb OK");
        else
            $display("sm4_block_cipher_tb NOT OK");
        $finish;
    end

endmodule
